/* src/vmt_pkg.sv */
// Shared types and constants for the vector move-towards unit.
package vmt_pkg;

   // Widths of the fixed-point datapath.
   localparam int COORD_W   = 32;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int SQ_W      = 2 * COORD_W;
   localparam int LEN_W     = SQ_W + 2;
   localparam int ROOT_W    = 33;
   localparam int ROOT_CELLS = ROOT_W;
   localparam int QUOT_W    = 32;
   localparam int DIV_CELLS = QUOT_W;
   localparam int NUM_W     = 64;
   localparam int AXES      = 3;

   // Per-item values that ride along with the arithmetic.
   typedef struct packed {
      logic [AXES-1:0][COORD_W-1:0] cur;
      logic [AXES-1:0][COORD_W-1:0] tgt;
      logic [AXES-1:0][COORD_W-1:0] dmag;
      logic [AXES-1:0]              dneg;
      logic [COORD_W-1:0]           mmag;
      logic                         mneg;
      logic                         snap;
   } vmt_carry_type;

   // One stage of the square root chain.
   typedef struct packed {
      logic                valid;
      logic [LEN_W-1:0]    rem;
      logic [ROOT_W-1:0]   root;
      vmt_carry_type       carry;
   } vmt_sqrt_type;

   // One stage of the divider chain, three lanes sharing one divisor.
   typedef struct packed {
      logic                          valid;
      logic [AXES-1:0][NUM_W-1:0]    rem;
      logic [AXES-1:0][QUOT_W-1:0]   quot;
      logic [ROOT_W-1:0]             divisor;
      vmt_carry_type                 carry;
   } vmt_div_type;

   // One result item.
   typedef struct packed {
      logic [AXES-1:0][COORD_W-1:0] pos;
      logic                         reached;
   } vmt_result_type;

endpackage

/* src/vmt_sqrt_cell.sv */
// One bit of the digit-by-digit integer square root chain.
module vmt_sqrt_cell
   import vmt_pkg::*;
#(
   parameter int BIT = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  vmt_sqrt_type stage_i,
   output vmt_sqrt_type stage_o
);

   vmt_sqrt_type     stage_ff;
   vmt_sqrt_type     stage_in;
   logic [LEN_W-1:0] trial;

   // Trial is (root + 2^BIT)^2 - root^2; take the bit when it fits.
   always_comb begin
      trial = ({{(LEN_W-ROOT_W){1'b0}}, stage_i.root} << (BIT + 1))
            | ({{(LEN_W-1){1'b0}}, 1'b1} << (2 * BIT));
      stage_in = stage_i;
      if (stage_i.rem >= trial) begin
         stage_in.rem  = stage_i.rem - trial;
         stage_in.root = stage_i.root | ({{(ROOT_W-1){1'b0}}, 1'b1} << BIT);
      end
   end

   // Stage register; only the valid bit is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

/* src/vmt_div_cell.sv */
// One quotient bit of the restoring divider chain, for all three axes.
module vmt_div_cell
   import vmt_pkg::*;
#(
   parameter int BIT = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  vmt_div_type stage_i,
   output vmt_div_type stage_o
);

   vmt_div_type      stage_ff;
   vmt_div_type      stage_in;
   logic [NUM_W:0]   shifted;

   // Subtract the divisor shifted to this bit where the remainder allows it.
   always_comb begin
      shifted  = {{(NUM_W+1-ROOT_W){1'b0}}, stage_i.divisor} << BIT;
      stage_in = stage_i;
      for (int a = 0; a < AXES; a++) begin
         if ({1'b0, stage_i.rem[a]} >= shifted) begin
            stage_in.rem[a]  = stage_i.rem[a] - shifted[NUM_W-1:0];
            stage_in.quot[a] = stage_i.quot[a] | ({{(QUOT_W-1){1'b0}}, 1'b1} << BIT);
         end
      end
   end

   // Stage register; only the valid bit is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule

/* src/vector_move_towards_unit.sv */
// Top level of the vector move-towards unit: front stages, cell chains, output.
//
// Moves a 3D point (signed fixed point) towards a target by at most
// max_distance; a negative step moves it away. One item enters on the req_
// channel, one result item leaves on the rsp_ channel.
// An item passes 70 registers: three front stages (difference, squares,
// length sum), 33 square root cells, one product stage, 32 divider cells
// and the output register. Throughput is one item per cycle while the
// chain is not held; every cell hands its item to the next one each
// cycle unless req_stall holds the chain, so up to 71 items can be in
// flight with the skid register.
// When the receiver stalls, the waiting result stays in the output register
// and one further item is caught in a skid register; only then does
// req_stall rise and the whole chain hold.
// Reset clears every valid bit at once; the unit takes items in the cycle
// after reset falls.
module vector_move_towards_unit
   import vmt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_cur_x,
   input  logic signed [31:0] req_cur_y,
   input  logic signed [31:0] req_cur_z,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic signed [31:0] req_max_distance,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_new_x,
   output logic signed [31:0] rsp_new_y,
   output logic signed [31:0] rsp_new_z,
   output logic               rsp_reached
);

   logic en;

   logic [AXES-1:0][COORD_W-1:0] req_cur;
   logic [AXES-1:0][COORD_W-1:0] req_tgt;
   logic [AXES-1:0][DIFF_W-1:0]  diff_in;

   logic                         s1_valid_ff;
   logic [AXES-1:0][COORD_W-1:0] s1_cur_ff;
   logic [AXES-1:0][COORD_W-1:0] s1_tgt_ff;
   logic [AXES-1:0][DIFF_W-1:0]  s1_diff_ff;
   logic [COORD_W-1:0]           s1_m_ff;

   logic [AXES-1:0][DIFF_W-1:0]  neg_diff;
   logic [AXES-1:0][COORD_W-1:0] dmag_in;
   logic [COORD_W-1:0]           mmag_in;

   logic                         s2_valid_ff;
   vmt_carry_type                s2_carry_ff;
   vmt_carry_type                s2_carry_in;
   logic [AXES-1:0][SQ_W-1:0]    s2_sq_ff;
   logic [SQ_W-1:0]              s2_mm_ff;

   logic [LEN_W-1:0]             len_sum;
   vmt_sqrt_type                 s3_ff;
   vmt_sqrt_type                 s3_in;

   vmt_sqrt_type                 sq_chain [ROOT_CELLS+1];
   vmt_div_type                  dv_chain [DIV_CELLS+1];
   vmt_div_type                  mul_ff;
   vmt_div_type                  mul_in;

   vmt_div_type                  tail;
   vmt_result_type               tail_res;
   logic [AXES-1:0][COORD_W:0]   off;
   logic [AXES-1:0][COORD_W+1:0] moved;

   vmt_result_type               rsp_ff;
   logic                         rsp_valid_ff;
   vmt_result_type               skid_ff;
   logic                         skid_valid_ff;

   // The chain moves unless the skid register is holding an item.
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Difference vector, one bit wider than a coordinate.
   assign req_cur = {req_cur_z, req_cur_y, req_cur_x};
   assign req_tgt = {req_target_z, req_target_y, req_target_x};
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         diff_in[a] = {req_tgt[a][COORD_W-1], req_tgt[a]}
                    - {req_cur[a][COORD_W-1], req_cur[a]};
      end
   end

   // Stage one: capture the item with its difference vector.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
      if (en) begin
         s1_cur_ff  <= req_cur;
         s1_tgt_ff  <= req_tgt;
         s1_diff_ff <= diff_in;
         s1_m_ff    <= req_max_distance;
      end
   end

   // Magnitudes of the difference and the step.
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         neg_diff[a] = -s1_diff_ff[a];
         dmag_in[a]  = s1_diff_ff[a][DIFF_W-1] ? neg_diff[a][COORD_W-1:0]
                                               : s1_diff_ff[a][COORD_W-1:0];
      end
      mmag_in = s1_m_ff[COORD_W-1] ? (-s1_m_ff) : s1_m_ff;
      s2_carry_in.cur  = s1_cur_ff;
      s2_carry_in.tgt  = s1_tgt_ff;
      s2_carry_in.dmag = dmag_in;
      for (int a = 0; a < AXES; a++) begin
         s2_carry_in.dneg[a] = s1_diff_ff[a][DIFF_W-1];
      end
      s2_carry_in.mmag = mmag_in;
      s2_carry_in.mneg = s1_m_ff[COORD_W-1];
      s2_carry_in.snap = 1'b0;
   end

   // Stage two: squares of each axis and of the step.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_carry_ff <= s2_carry_in;
         for (int a = 0; a < AXES; a++) begin
            s2_sq_ff[a] <= SQ_W'(dmag_in[a]) * SQ_W'(dmag_in[a]);
         end
         s2_mm_ff <= SQ_W'(mmag_in) * SQ_W'(mmag_in);
      end
   end

   // Squared length and the snap decision.
   always_comb begin
      len_sum = {2'b00, s2_sq_ff[0]} + {2'b00, s2_sq_ff[1]} + {2'b00, s2_sq_ff[2]};
      s3_in.valid      = s2_valid_ff;
      s3_in.rem        = len_sum;
      s3_in.root       = '0;
      s3_in.carry      = s2_carry_ff;
      s3_in.carry.snap = (len_sum == '0)
                       || (!s2_carry_ff.mneg && (len_sum <= {2'b00, s2_mm_ff}));
   end

   // Stage three: feeds the square root chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else if (en) begin
         s3_ff <= s3_in;
      end
   end

   // Square root chain, most significant root bit first.
   assign sq_chain[0] = s3_ff;
   for (genvar c = 0; c < ROOT_CELLS; c++) begin : g_sqrt
      vmt_sqrt_cell #(
         .BIT(ROOT_CELLS - 1 - c)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .stage_i(sq_chain[c]),
         .stage_o(sq_chain[c+1])
      );
   end

   // Numerators |d| * |step| for the divider.
   always_comb begin
      mul_in.valid   = sq_chain[ROOT_CELLS].valid;
      mul_in.divisor = sq_chain[ROOT_CELLS].root;
      mul_in.carry   = sq_chain[ROOT_CELLS].carry;
      mul_in.quot    = '0;
      for (int a = 0; a < AXES; a++) begin
         mul_in.rem[a] = NUM_W'(sq_chain[ROOT_CELLS].carry.dmag[a])
                       * NUM_W'(sq_chain[ROOT_CELLS].carry.mmag);
      end
   end

   // Product stage: feeds the divider chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff.valid <= 1'b0;
      end else if (en) begin
         mul_ff <= mul_in;
      end
   end

   // Divider chain, most significant quotient bit first.
   assign dv_chain[0] = mul_ff;
   for (genvar c = 0; c < DIV_CELLS; c++) begin : g_div
      vmt_div_cell #(
         .BIT(DIV_CELLS - 1 - c)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .stage_i(dv_chain[c]),
         .stage_o(dv_chain[c+1])
      );
   end

   // Signed offset, saturating add, or the target on a snap.
   assign tail = dv_chain[DIV_CELLS];
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         off[a]   = (tail.carry.dneg[a] != tail.carry.mneg)
                  ? -{1'b0, tail.quot[a]} : {1'b0, tail.quot[a]};
         moved[a] = {{2{tail.carry.cur[a][COORD_W-1]}}, tail.carry.cur[a]}
                  + {off[a][COORD_W], off[a]};
         if (tail.carry.snap) begin
            tail_res.pos[a] = tail.carry.tgt[a];
         end else if (moved[a][COORD_W+1]
                      && !(moved[a][COORD_W] && moved[a][COORD_W-1])) begin
            tail_res.pos[a] = {1'b1, {(COORD_W-1){1'b0}}};
         end else if (!moved[a][COORD_W+1] && (moved[a][COORD_W] || moved[a][COORD_W-1])) begin
            tail_res.pos[a] = {1'b0, {(COORD_W-1){1'b1}}};
         end else begin
            tail_res.pos[a] = moved[a][COORD_W-1:0];
         end
      end
      tail_res.reached = tail.carry.snap;
   end

   // Output register with a one-item skid behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= tail.valid;
         end
      end else if (en && tail.valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_ff <= skid_valid_ff ? skid_ff : tail_res;
      end else if (en && tail.valid) begin
         skid_ff <= tail_res;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_new_x   = rsp_ff.pos[0];
   assign rsp_new_y   = rsp_ff.pos[1];
   assign rsp_new_z   = rsp_ff.pos[2];
   assign rsp_reached = rsp_ff.reached;

   // The skid register only holds an item behind a waiting result.
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   // The skid register fills only when the receiver stalled a result.
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid register filled without a stalled result");

   // The root leaving the chain is the floor square root.
   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      sq_chain[ROOT_CELLS].valid |->
         (sq_chain[ROOT_CELLS].rem <= {{(LEN_W-ROOT_W-1){1'b0}}, sq_chain[ROOT_CELLS].root, 1'b0}))
      else $error("square root remainder out of range");

   // Division remainders end below the divisor on a moving item.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (tail.valid && !tail.carry.snap) |->
         ((tail.rem[0] < NUM_W'(tail.divisor)) && (tail.rem[1] < NUM_W'(tail.divisor))
          && (tail.rem[2] < NUM_W'(tail.divisor))))
      else $error("division remainder not below divisor");

endmodule
